>>> rtl/core/fbpa_pkg.sv
// fbpa_pkg: shared types and constants for the fixed block pool allocator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int BLOCKS       = 1024;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int PAGE_W       = 17;
  localparam int STRIDE_W     = 18;
  localparam int ADDR_W       = 32;
  localparam int PROD_W       = IDX_W + STRIDE_W;
  localparam int PREFIX_BYTES = 8;
  localparam int MIN_PAGE     = 8;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_PAGE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic sweep;
    logic sweep_links;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       page_ok;
    logic       sweep_last;
    logic       slot_free;
  } dp_status_t;

endpackage

>>> rtl/core/fbpa_ctrl.sv
// fbpa_ctrl: sequencer for the block pool allocator.
// Depends on fbpa_pkg for the command and status structs.
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  fbpa_pkg::dp_status_t   status,
  output fbpa_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.read = 1'b1;
        if (status.cmd == fbpa_pkg::CMD_REINIT && status.page_ok) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_links = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register can take the result
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          req_ready  = 1'b1;
          if (req_valid) begin
            cmd.load   = 1'b1;
            state_next = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/fbpa_dp.sv
// fbpa_dp: registers, link and used-flag memories, address math and result register.
// Depends on fbpa_pkg; driven by fbpa_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps

module fbpa_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic [1:0]               command,
  input  logic [31:0]              request_bytes,
  input  logic [2:0]               align_log2,
  input  logic [9:0]               block_index,
  input  logic                     null_free,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic                     ok,
  output logic [9:0]               granted_index,
  output logic [31:0]              granted_addr,
  input  fbpa_pkg::ctrl_cmd_t      cmd,
  output fbpa_pkg::dp_status_t     status
);

  localparam int IDX_W = fbpa_pkg::IDX_W;
  localparam int CNT_W = fbpa_pkg::CNT_W;

  // configuration
  logic [31:0]                       base_addr;
  logic [fbpa_pkg::PAGE_W-1:0]       page_size;
  logic [CNT_W-1:0]                  block_count;

  // captured item
  logic [1:0]       cmd_r;
  logic [31:0]      req_r;
  logic [2:0]       align_r;
  logic [IDX_W-1:0] idx_r;
  logic             null_r;

  // list state
  logic [IDX_W-1:0] head;
  logic             empty;
  logic [IDX_W-1:0] sweep_idx;

  // memories: link word is {bottom, next}
  logic [IDX_W:0]   link_mem [fbpa_pkg::BLOCKS];
  logic             used_mem [fbpa_pkg::BLOCKS];
  logic [IDX_W:0]   link_rd;
  logic             used_rd;
  logic [fbpa_pkg::PROD_W-1:0] prod;

  logic [fbpa_pkg::STRIDE_W-1:0] stride;
  logic [fbpa_pkg::ADDR_W-1:0]   addr;
  logic [6:0]                    align_mask;
  logic [CNT_W-1:0]              count_sat;
  logic                          page_ok;
  logic                          alloc_ok;
  logic                          push_ok;
  logic                          reinit_ok;
  logic                          result_ok;

  logic             link_we;
  logic [IDX_W-1:0] link_wa;
  logic [IDX_W:0]   link_wd;
  logic             used_we;
  logic [IDX_W-1:0] used_wa;
  logic             used_wd;

  assign stride = {1'b0, page_size} + fbpa_pkg::STRIDE_W'(fbpa_pkg::PREFIX_BYTES);
  assign addr   = base_addr + fbpa_pkg::ADDR_W'(prod);
  assign align_mask = ~(7'h7f << align_r);
  assign page_ok = page_size >= fbpa_pkg::PAGE_W'(fbpa_pkg::MIN_PAGE);
  assign count_sat = (block_count > CNT_W'(fbpa_pkg::BLOCKS)) ?
                     CNT_W'(fbpa_pkg::BLOCKS) : block_count;

  assign alloc_ok  = (cmd_r == fbpa_pkg::CMD_ALLOC) && !empty &&
                     (req_r <= {15'd0, page_size}) && ((addr[6:0] & align_mask) == 7'd0);
  assign push_ok   = (cmd_r == fbpa_pkg::CMD_FREE) && !null_r && used_rd;
  assign reinit_ok = (cmd_r == fbpa_pkg::CMD_REINIT) && page_ok;
  assign result_ok = alloc_ok || push_ok || reinit_ok ||
                     ((cmd_r == fbpa_pkg::CMD_FREE) && null_r);

  assign status.cmd        = cmd_r;
  assign status.page_ok    = page_ok;
  assign status.sweep_last = &sweep_idx;
  assign status.slot_free  = !rsp_valid || rsp_ready;

  // memory write selection
  always_comb begin
    link_we = 1'b0;
    link_wa = sweep_idx;
    link_wd = {1'b1, {IDX_W{1'b0}}};
    used_we = 1'b0;
    used_wa = sweep_idx;
    used_wd = 1'b0;
    if (cmd.sweep) begin
      used_we = 1'b1;
      if (cmd.sweep_links && ({1'b0, sweep_idx} < count_sat)) begin
        link_we = 1'b1;
        // block 0 is the tail, every other block below the count links to the one below it
        link_wd = (sweep_idx == '0) ? {1'b1, {IDX_W{1'b0}}} : {1'b0, sweep_idx - 1'b1};
      end
    end else if (cmd.commit && alloc_ok) begin
      used_we = 1'b1;
      used_wa = head;
      used_wd = 1'b1;
    end else if (cmd.commit && push_ok) begin
      used_we = 1'b1;
      used_wa = idx_r;
      link_we = 1'b1;
      link_wa = idx_r;
      link_wd = {empty, head};
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.read) begin
      link_rd <= link_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (cmd.read) begin
      used_rd <= used_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      prod <= {{fbpa_pkg::STRIDE_W{1'b0}}, head} * {{IDX_W{1'b0}}, stride};
    end
    if (cmd.load) begin
      cmd_r   <= command;
      req_r   <= request_bytes;
      align_r <= align_log2;
      idx_r   <= block_index;
      null_r  <= null_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr   <= '0;
      page_size   <= fbpa_pkg::PAGE_W'(64);
      block_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbpa_pkg::REG_BASE:  base_addr   <= cfg_data;
        fbpa_pkg::REG_PAGE:  page_size   <= cfg_data[fbpa_pkg::PAGE_W-1:0];
        fbpa_pkg::REG_COUNT: block_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      empty     <= 1'b1;
      sweep_idx <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (cmd.commit) begin
        if (alloc_ok) begin
          if (link_rd[IDX_W]) begin
            empty <= 1'b1;
          end else begin
            head <= link_rd[IDX_W-1:0];
          end
        end else if (push_ok) begin
          head  <= idx_r;
          empty <= 1'b0;
        end else if (reinit_ok) begin
          head  <= (count_sat == '0) ? '0 : IDX_W'(count_sat - 1'b1);
          empty <= (count_sat == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok            <= result_ok;
      granted_index <= alloc_ok ? head : '0;
      granted_addr  <= alloc_ok ? addr : '0;
    end
  end

endmodule

>>> rtl/core/fixed_block_pool_allocator_core.sv
// fixed_block_pool_allocator_core: top level of the fixed-size block pool allocator.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
`timescale 1ns / 1ps
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  req     | req_valid/req_ready  | command, request_bytes, align_log2,
//          |                      | block_index, null_free
//  rsp     | rsp_valid/rsp_ready  | ok, granted_index, granted_addr
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// For alloc and free, ST_EXEC reads the link and used-flag memories and forms
// head * stride in the multiplier; ST_FINISH then commits.
// Reinit with a page size of at least 8 walks all 1024 entries of the used-flag memory, one per cycle.
// After reset a clearing pass over all 1024 entries empties the used flags; no item is taken then.
// A result waiting on rsp_ready holds the commit; the next item is taken meanwhile
// only once its predecessor has committed.

module fixed_block_pool_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  command,
  input  logic [31:0] request_bytes,
  input  logic [2:0]  align_log2,
  input  logic [9:0]  block_index,
  input  logic        null_free,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        ok,
  output logic [9:0]  granted_index,
  output logic [31:0] granted_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fbpa_pkg::ctrl_cmd_t  ctrl_cmd;
  fbpa_pkg::dp_status_t dp_status;

  // registers are writable at any time the block is idle
  assign cfg_ready = 1'b1;

  // sequencer: clearing pass, item intake, reinit sweep, commit
  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  // list state, memories, address arithmetic and result register
  fbpa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .request_bytes (request_bytes),
    .align_log2    (align_log2),
    .block_index   (block_index),
    .null_free     (null_free),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .ok            (ok),
    .granted_index (granted_index),
    .granted_addr  (granted_addr),
    .cmd           (ctrl_cmd),
    .status        (dp_status)
  );

endmodule

>>> rtl/core/fbpa_checker.sv
// fbpa_checker: port-level assertions for the block pool allocator, bound to the top.
// Depends only on the ports of fixed_block_pool_allocator_core.
`timescale 1ns / 1ps

module fbpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        ok,
  input logic [9:0]  granted_index,
  input logic [31:0] granted_addr
);

  // a pending result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(granted_index) &&
    $stable(granted_addr))
    else $error("result changed while stalled");

  // a failed command grants nothing
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ok |-> granted_index == 10'd0 && granted_addr == 32'd0)
    else $error("failed command carries a grant");

  // reset drops any pending result
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result pending after reset");

  // items are never taken back to back
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item taken on consecutive cycles");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_ready     (req_ready),
  .rsp_valid     (rsp_valid),
  .rsp_ready     (rsp_ready),
  .ok            (ok),
  .granted_index (granted_index),
  .granted_addr  (granted_addr)
);
